// ===== sv/lap7_pkg.sv =====
`default_nettype none
package lap7_pkg;

  // Field widths.
  localparam int unsigned IdxW  = 30;
  localparam int unsigned GridW = 11;
  localparam int unsigned CoefW = 21;
  localparam int unsigned ValW  = 24;
  localparam int unsigned CfgIW = 3;
  localparam int unsigned CfgDW = 21;

  // Quotient bits per division: coordinates stay below the grid size.
  localparam int unsigned QW     = GridW;
  localparam int unsigned PlaneW = 2 * GridW;
  localparam int unsigned RowsW  = 3 * GridW;
  localparam int unsigned TermW  = CoefW + 2;
  localparam int unsigned SumW   = CoefW + 4;
  localparam int unsigned NumEnt = 7;

  // Largest positive matrix value.
  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};

  // Configuration register indexes.
  localparam logic [CfgIW-1:0] RegGridX = 3'd0;
  localparam logic [CfgIW-1:0] RegGridY = 3'd1;
  localparam logic [CfgIW-1:0] RegGridZ = 3'd2;
  localparam logic [CfgIW-1:0] RegCoefX = 3'd3;
  localparam logic [CfgIW-1:0] RegCoefY = 3'd4;
  localparam logic [CfgIW-1:0] RegCoefZ = 3'd5;

  // One-hot entry codes, in emission order.
  localparam logic [NumEnt-1:0] EntDiag = 7'b0000001;
  localparam logic [NumEnt-1:0] EntZm   = 7'b0000010;
  localparam logic [NumEnt-1:0] EntYm   = 7'b0000100;
  localparam logic [NumEnt-1:0] EntXm   = 7'b0001000;
  localparam logic [NumEnt-1:0] EntXp   = 7'b0010000;
  localparam logic [NumEnt-1:0] EntYp   = 7'b0100000;
  localparam logic [NumEnt-1:0] EntZp   = 7'b1000000;

endpackage
`default_nettype wire

// ===== sv/laplacian_7pt_row_generator_core.sv =====
// Seven-point Laplacian row generator for a 3-D grid, CSR entry stream.
// Input channel: in_valid / in_stall carry one global row index per
// transaction. Output channel: out_valid / out_stall carry one matrix entry
// per transaction: the diagonal first, then the z-1, y-1, x-1, x+1, y+1 and
// z+1 neighbors that exist; out_last_entry marks the end of a row. A row
// index outside the grid yields one entry with out_bad_row set.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (grid
// sizes 0..2, coefficients 3..5); write only while the block is idle.
// Pipeline: one capture stage, 22 compare-subtract stages (11 for z, 11 for y),
// one neighbor stage, the entry sequencer and the output register.
// Throughput: one entry per cycle while the receiver does not stall; a row holds
// the sequencer until its last entry is loaded, and only then does a new row enter.
// Reset loads the default grid (10 x 10 x 10, coefficients 100) and empties
// the pipeline. When the receiver stalls, the output holds and the whole
// pipeline freezes once the sequencer is full; in_stall then rises.
`default_nettype none
module laplacian_7pt_row_generator_core
  import lap7_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CfgIW-1:0]         cfg_index,
  input  wire logic [CfgDW-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [IdxW-1:0]          in_row_index,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [IdxW-1:0]               out_column_index,
  output logic signed [ValW-1:0]        out_entry_value,
  output logic                          out_is_diagonal,
  output logic                          out_last_entry,
  output logic                          out_bad_row
);

  localparam int unsigned DimW = 13;
  localparam int unsigned ND   = 2 * QW;

  // Configuration registers.
  logic [GridW-1:0] grid_x_r, grid_y_r, grid_z_r;
  logic [CoefW-1:0] coef_x_r, coef_y_r, coef_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= GridW'(10);
      grid_y_r <= GridW'(10);
      grid_z_r <= GridW'(10);
      coef_x_r <= CoefW'(100);
      coef_y_r <= CoefW'(100);
      coef_z_r <= CoefW'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegGridX: grid_x_r <= cfg_data[GridW-1:0];
        RegGridY: grid_y_r <= cfg_data[GridW-1:0];
        RegGridZ: grid_z_r <= cfg_data[GridW-1:0];
        RegCoefX: coef_x_r <= cfg_data[CoefW-1:0];
        RegCoefY: coef_y_r <= cfg_data[CoefW-1:0];
        RegCoefZ: coef_z_r <= cfg_data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Saturated sizes and derived plane and row counts, each registered from the one before.
  logic [GridW-1:0]  gx_r, gy_r, gz_r;
  logic [PlaneW-1:0] plane_r;
  logic [RowsW-1:0]  rows_r;

  always_ff @(posedge clk) begin
    gx_r    <= ({2'b0, grid_x_r} > DimW'(MAX_DIM)) ? GridW'(MAX_DIM) : grid_x_r;
    gy_r    <= ({2'b0, grid_y_r} > DimW'(MAX_DIM)) ? GridW'(MAX_DIM) : grid_y_r;
    gz_r    <= ({2'b0, grid_z_r} > DimW'(MAX_DIM)) ? GridW'(MAX_DIM) : grid_z_r;
    plane_r <= gx_r * gy_r;
    rows_r  <= plane_r * gz_r;
  end

  // Pipeline advance: everything moves when the sequencer can take a row.
  logic en;
  assign in_stall = !en;

  // Division stages: stage 0 is the capture, stage k+1 follows step k.
  logic            v_r   [0:ND];
  logic [IdxW-1:0] idx_r [0:ND];
  logic [IdxW-1:0] rem_r [0:ND];
  logic [QW-1:0]   qz_r  [0:ND];
  logic [QW-1:0]   qy_r  [0:ND];
  logic [IdxW-1:0] rem_nxt [0:ND-1];
  logic [QW-1:0]   qz_nxt  [0:ND-1];
  logic [QW-1:0]   qy_nxt  [0:ND-1];

  // One restoring step per stage: z by plane, then y by gx.
  always_comb begin
    logic [RowsW-1:0] sh;
    logic             ge;
    for (int k = 0; k < ND; k++) begin
      if (k < QW) sh = {{GridW{1'b0}}, plane_r} << (QW - 1 - k);
      else        sh = {{PlaneW{1'b0}}, gx_r} << (ND - 1 - k);
      ge = {3'b0, rem_r[k]} >= sh;
      rem_nxt[k] = ge ? (rem_r[k] - sh[IdxW-1:0]) : rem_r[k];
      qz_nxt[k]  = qz_r[k];
      qy_nxt[k]  = qy_r[k];
      if (k < QW) qz_nxt[k][QW-1-k] = ge;
      else        qy_nxt[k][ND-1-k] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ND; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < ND; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= in_row_index;
      rem_r[0] <= in_row_index;
      qz_r[0]  <= '0;
      qy_r[0]  <= '0;
      for (int k = 0; k < ND; k++) begin
        idx_r[k+1] <= idx_r[k];
        rem_r[k+1] <= rem_nxt[k];
        qz_r[k+1]  <= qz_nxt[k];
        qy_r[k+1]  <= qy_nxt[k];
      end
    end
  end

  // Neighbor stage: existence flags and per-axis diagonal contributions.
  logic [QW-1:0]    cx, cy, cz;
  logic [5:0]       nb_flags;
  logic [TermW-1:0] t_zm, t_ym, t_xm, t_xp, t_yp, t_zp;

  assign cx = rem_r[ND][QW-1:0];
  assign cy = qy_r[ND];
  assign cz = qz_r[ND];

  always_comb begin
    nb_flags[0] = cz != '0;
    nb_flags[1] = cy != '0;
    nb_flags[2] = cx != '0;
    nb_flags[3] = ({1'b0, cx} + 1'b1) < {1'b0, gx_r};
    nb_flags[4] = ({1'b0, cy} + 1'b1) < {1'b0, gy_r};
    nb_flags[5] = ({1'b0, cz} + 1'b1) < {1'b0, gz_r};
    t_zm = nb_flags[0] ? TermW'(coef_z_r) : ((gz_r > 1) ? TermW'({coef_z_r, 1'b0}) : '0);
    t_ym = nb_flags[1] ? TermW'(coef_y_r) : ((gy_r > 1) ? TermW'({coef_y_r, 1'b0}) : '0);
    t_xm = nb_flags[2] ? TermW'(coef_x_r) : ((gx_r > 1) ? TermW'({coef_x_r, 1'b0}) : '0);
    t_xp = nb_flags[3] ? TermW'(coef_x_r) : ((gx_r > 1) ? TermW'({coef_x_r, 1'b0}) : '0);
    t_yp = nb_flags[4] ? TermW'(coef_y_r) : ((gy_r > 1) ? TermW'({coef_y_r, 1'b0}) : '0);
    t_zp = nb_flags[5] ? TermW'(coef_z_r) : ((gz_r > 1) ? TermW'({coef_z_r, 1'b0}) : '0);
  end

  logic             b_v_r;
  logic [IdxW-1:0]  b_idx_r;
  logic             b_bad_r;
  logic [5:0]       b_flags_r;
  logic [TermW-1:0] b_sx_r, b_sy_r, b_sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= v_r[ND];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_idx_r   <= idx_r[ND];
      b_bad_r   <= (rows_r == '0) || ({3'b0, idx_r[ND]} >= rows_r);
      b_flags_r <= nb_flags;
      b_sx_r    <= t_xm + t_xp;
      b_sy_r    <= t_ym + t_yp;
      b_sz_r    <= t_zm + t_zp;
    end
  end

  // Entry sequencer: a mask of entries still to send for the current row.
  logic [NumEnt-1:0] mask_r;
  logic [IdxW-1:0]   e_idx_r;
  logic [ValW-1:0]   e_diag_r;
  logic              e_bad_r;
  logic              out_valid_r;
  logic [NumEnt-1:0] pick, rest, mask_new;
  logic              load;
  logic [SumW-1:0]   diag_sum;
  logic [ValW-1:0]   diag_sat;

  assign load = (mask_r != '0) && (!out_valid_r || !out_stall);
  assign pick = mask_r & (~mask_r + 1'b1);
  assign rest = mask_r & ~pick;
  assign en   = (mask_r == '0) || (load && (rest == '0));

  assign diag_sum = SumW'(b_sx_r) + SumW'(b_sy_r) + SumW'(b_sz_r);
  assign diag_sat = (diag_sum > SumW'(ValMax)) ? ValMax : diag_sum[ValW-1:0];
  assign mask_new = b_bad_r ? EntDiag : {b_flags_r, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (en) begin
      mask_r <= b_v_r ? mask_new : '0;
    end else if (load) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_idx_r  <= b_idx_r;
      e_diag_r <= diag_sat;
      e_bad_r  <= b_bad_r;
    end
  end

  // Entry selection: column offset and value for the chosen neighbor.
  logic [IdxW-1:0] sel_col;
  logic [ValW-1:0] sel_val;

  always_comb begin
    sel_col = e_idx_r;
    sel_val = e_diag_r;
    case (pick)
      EntDiag: begin
        sel_col = e_idx_r;
        sel_val = e_diag_r;
      end
      EntZm: begin
        sel_col = e_idx_r - IdxW'(plane_r);
        sel_val = ValW'(0) - ValW'(coef_z_r);
      end
      EntYm: begin
        sel_col = e_idx_r - IdxW'(gx_r);
        sel_val = ValW'(0) - ValW'(coef_y_r);
      end
      EntXm: begin
        sel_col = e_idx_r - 1'b1;
        sel_val = ValW'(0) - ValW'(coef_x_r);
      end
      EntXp: begin
        sel_col = e_idx_r + 1'b1;
        sel_val = ValW'(0) - ValW'(coef_x_r);
      end
      EntYp: begin
        sel_col = e_idx_r + IdxW'(gx_r);
        sel_val = ValW'(0) - ValW'(coef_y_r);
      end
      EntZp: begin
        sel_col = e_idx_r + IdxW'(plane_r);
        sel_val = ValW'(0) - ValW'(coef_z_r);
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_column_index <= e_bad_r ? '0 : sel_col;
      out_entry_value  <= e_bad_r ? '0 : sel_val;
      out_is_diagonal  <= !e_bad_r && (pick == EntDiag);
      out_last_entry   <= rest == '0;
      out_bad_row      <= e_bad_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // A flagged row is always a single, final entry.
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_row |-> out_last_entry && !out_is_diagonal)
    else $error("bad row entry not marked last");

  // The pipeline only moves when the sequencer has room for a new row.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (mask_r == '0) || (load && (rest == '0)))
    else $error("pipeline advanced over a busy sequencer");

  // A row loaded into the sequencer always starts with its diagonal.
  a_diag_first: assert property (@(posedge clk) disable iff (!rst_n)
    en && b_v_r |=> mask_r[0])
    else $error("row loaded without diagonal");
`endif

endmodule
`default_nettype wire

// ===== tb/lap7_row_checker.sv =====
`default_nettype none
module lap7_row_checker
  import lap7_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CfgIW-1:0]      cfg_index,
  input  wire logic [CfgDW-1:0]      cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [IdxW-1:0]       in_row_index,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [IdxW-1:0]       out_column_index,
  input  wire logic signed [ValW-1:0] out_entry_value,
  input  wire logic                  out_is_diagonal,
  input  wire logic                  out_last_entry,
  input  wire logic                  out_bad_row,
  output int                         fail_count,
  output int                         pending_entries,
  output int                         entries_seen,
  output int                         rows_seen
);

  typedef struct packed {
    logic [IdxW-1:0] col;
    logic [ValW-1:0] val;
    logic            diag;
    logic            last;
    logic            bad;
  } matrix_entry_t;

  matrix_entry_t entry_queue[$];
  logic [GridW-1:0] size_x, size_y, size_z;
  logic [CoefW-1:0] weight_x, weight_y, weight_z;

  function automatic longint unsigned clamp_dim(logic [GridW-1:0] g);
    return (g > 1024) ? 1024 : g;
  endfunction

  function automatic matrix_entry_t neighbor(longint unsigned col, logic [CoefW-1:0] w);
    matrix_entry_t e;
    e.col = col[IdxW-1:0];
    e.val = ValW'(-longint'(w));
    e.diag = 1'b0;
    e.last = 1'b0;
    e.bad = 1'b0;
    return e;
  endfunction

  // Expand one row index into the entries the block should emit.
  task automatic predict_row(logic [IdxW-1:0] row);
    longint unsigned gx, gy, gz, plane, rows, idx, px, py, pz, dsum;
    matrix_entry_t nb[$];
    matrix_entry_t d;
    gx = clamp_dim(size_x);
    gy = clamp_dim(size_y);
    gz = clamp_dim(size_z);
    plane = gx * gy;
    rows = plane * gz;
    idx = row;
    dsum = 0;
    if (rows == 0 || idx >= rows) begin
      d = '0;
      d.last = 1'b1;
      d.bad = 1'b1;
      entry_queue.push_back(d);
      return;
    end
    px = idx % gx;
    py = (idx / gx) % gy;
    pz = idx / plane;
    if (pz > 0) begin
      dsum += weight_z; nb.push_back(neighbor(idx - plane, weight_z));
    end else if (gz > 1) dsum += 2 * weight_z;
    if (py > 0) begin
      dsum += weight_y; nb.push_back(neighbor(idx - gx, weight_y));
    end else if (gy > 1) dsum += 2 * weight_y;
    if (px > 0) begin
      dsum += weight_x; nb.push_back(neighbor(idx - 1, weight_x));
    end else if (gx > 1) dsum += 2 * weight_x;
    if (px + 1 < gx) begin
      dsum += weight_x; nb.push_back(neighbor(idx + 1, weight_x));
    end else if (gx > 1) dsum += 2 * weight_x;
    if (py + 1 < gy) begin
      dsum += weight_y; nb.push_back(neighbor(idx + gx, weight_y));
    end else if (gy > 1) dsum += 2 * weight_y;
    if (pz + 1 < gz) begin
      dsum += weight_z; nb.push_back(neighbor(idx + plane, weight_z));
    end else if (gz > 1) dsum += 2 * weight_z;
    if (dsum > 8388607) dsum = 8388607;
    d.col = row;
    d.val = dsum[ValW-1:0];
    d.diag = 1'b1;
    d.last = (nb.size() == 0);
    d.bad = 1'b0;
    entry_queue.push_back(d);
    foreach (nb[i]) begin
      if (i == nb.size() - 1) nb[i].last = 1'b1;
      entry_queue.push_back(nb[i]);
    end
  endtask

  // Track registers, predict on each input transaction, check each output one.
  always @(posedge clk) begin
    matrix_entry_t want, got;
    if (!rst_n) begin
      size_x <= 10; size_y <= 10; size_z <= 10;
      weight_x <= 100; weight_y <= 100; weight_z <= 100;
      entry_queue.delete();
      fail_count <= 0;
      entries_seen <= 0;
      rows_seen <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          RegGridX: size_x <= cfg_data[GridW-1:0];
          RegGridY: size_y <= cfg_data[GridW-1:0];
          RegGridZ: size_z <= cfg_data[GridW-1:0];
          RegCoefX: weight_x <= cfg_data[CoefW-1:0];
          RegCoefY: weight_y <= cfg_data[CoefW-1:0];
          RegCoefZ: weight_z <= cfg_data[CoefW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_row(in_row_index);
        rows_seen <= rows_seen + 1;
      end
      if (out_valid && !out_stall) begin
        entries_seen <= entries_seen + 1;
        got = '{out_column_index, out_entry_value, out_is_diagonal, out_last_entry,
                out_bad_row};
        if (entry_queue.size() == 0) begin
          $display("%0t: unexpected entry, expected none, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = entry_queue.pop_front();
          if (got !== want) begin
            $display("%0t: entry mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_entries = entry_queue.size();
  end

endmodule
`default_nettype wire

// ===== tb/tb_laplacian_7pt_row_generator_core.sv =====
`default_nettype none
module tb_laplacian_7pt_row_generator_core;
  import lap7_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CfgIW-1:0] cfg_index = '0;
  logic [CfgDW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [IdxW-1:0] in_row_index = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_is_diagonal, out_last_entry, out_bad_row;
  logic [IdxW-1:0] out_column_index;
  logic signed [ValW-1:0] out_entry_value;
  int fail_count, pending_entries, entries_seen, rows_seen;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  laplacian_7pt_row_generator_core u_dut (.*);

  lap7_row_checker u_checker (.*);

  // Receiver stalls at random, or holds off completely during a long stretch.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Generous limit on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout with %0d entries pending", pending_entries);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIW-1:0] idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgDW-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Let the pipeline drain before touching registers.
  task automatic wait_idle();
    while (pending_entries != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned gx, gy, gz, cx, cy, cz);
    write_reg(RegGridX, gx);
    write_reg(RegGridY, gy);
    write_reg(RegGridZ, gz);
    write_reg(RegCoefX, cx);
    write_reg(RegCoefY, cy);
    write_reg(RegCoefZ, cz);
  endtask

  // Offer one row index and hold it until the block takes it. The stall is
  // sampled at the falling edge before each rising edge, where it is settled.
  task automatic send_row(logic [IdxW-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_index <= row;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly rows inside the grid, some just past it, some anywhere.
  function automatic logic [IdxW-1:0] pick_row(int unsigned rows);
    int unsigned r;
    r = $urandom_range(9);
    if (rows == 0 || r == 0) return IdxW'($urandom());
    if (r == 1) return IdxW'(rows + $urandom_range(3));
    return IdxW'($urandom_range(rows - 1));
  endfunction

  task automatic random_phase(int unsigned gx, gy, gz, int n);
    int unsigned rows;
    rows = gx * gy * gz;
    set_grid(gx, gy, gz, $urandom_range(1048576), $urandom_range(1048576),
             $urandom_range(1 << $urandom_range(20)));
    for (int i = 0; i < n; i++) send_row(pick_row(rows));
    pause_sender();
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, interior, and out of range on the reset grid.
    send_row(0); send_row(9); send_row(555); send_row(999);
    send_row(1000); send_row('1);
    pause_sender();
    wait_idle();
    // Single-point axes, oversize dimension, overflow of the diagonal sum.
    set_grid(1, 1, 1, 1048576, 1048576, 1048576);
    send_row(0); send_row(1);
    pause_sender(); wait_idle();
    set_grid(2047, 1, 1, 1048576, 0, 0);
    send_row(0); send_row(1023); send_row(1024); send_row(500);
    pause_sender(); wait_idle();
    set_grid(3, 3, 3, 2097151, 2097151, 2097151);
    send_row(13); send_row(0); send_row(26); send_row(27);
    pause_sender(); wait_idle();
    set_grid(0, 5, 5, 1, 2, 3);
    send_row(0); send_row(7);
    pause_sender(); wait_idle();
    set_grid(1024, 1024, 1024, 7, 11, 13);
    send_row(0); send_row(30'h3FFF_FFFF); send_row(30'h2000_0000);
    send_row(1024 * 1024 + 1025);
    pause_sender(); wait_idle();
    write_reg(3'd7, 5);
    send_row(0);
    pause_sender(); wait_idle();

    // Random phases under different idling mixes.
    random_phase(4, 3, 5, 15);
    send_idle_pct = 54;
    random_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 15);
    send_idle_pct = 0; recv_stall_pct = 54;
    random_phase($urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(1, 30), 15);
    send_idle_pct = 14; recv_stall_pct = 14;
    random_phase(1024, $urandom_range(1, 1024), $urandom_range(1, 4), 15);

    // Long hold-off on the receiver while the sender keeps pushing, enough
    // rows to fill the pipeline and stall the input.
    send_idle_pct = 0; recv_stall_pct = 0;
    set_grid(6, 6, 6, 100, 200, 300);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_row(IdxW'($urandom_range(215)));
    join
    pause_sender();
    wait_idle();

    $display("Covered %0d rows and %0d matrix entries across grid shapes and idling mixes.",
             rows_seen, entries_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
